// ===== hw/rtl/sdd_pkg.sv =====
// Package for the sensor datagram deframer.
// Holds shared types, result kinds and framing constants; no dependencies.
`default_nettype none
package sdd_pkg;

  localparam int unsigned MaxDatagramBytes = 65535;
  localparam int unsigned RecordBytes = 40;
  localparam int unsigned PosW = 16;
  localparam int unsigned RecW = 6;
  localparam int unsigned AsmW = 24;
  localparam logic [AsmW-1:0] AsmMax = '1;
  localparam logic [PosW-1:0] SpecMin = 16'd13;
  localparam logic [PosW-1:0] SpecValueEnd = 16'd17;
  localparam logic [7:0] TypeRealtime = 8'h03;
  localparam logic [7:0] TypeSpectrum = 8'h04;
  localparam logic [7:0] HeaderByte = 8'hFF;
  localparam logic [7:0] StartHigh = 8'hFF;
  localparam logic [7:0] StartLow = 8'hEE;

  typedef enum logic [3:0] {
    KindRecord       = 4'd0,
    KindSpectrum     = 4'd1,
    KindStart        = 4'd2,
    KindRealtimeEnd  = 4'd3,
    KindShort        = 4'd4,
    KindBadHeader    = 4'd5,
    KindNoType       = 4'd6,
    KindUnknownType  = 4'd7,
    KindSpectrumShort = 4'd8
  } kind_e;

  // One queued event from the front part to the back part.
  typedef struct packed {
    logic             has_record;
    logic             has_end;
    kind_e            end_kind;
    logic [7:0]       rec_channel;
    logic [7:0]       rec_sensor;
    logic [31:0]      rec_a;
    logic [31:0]      rec_b;
    logic [7:0]       spec_channel;
    logic [7:0]       spec_sensor;
    logic [31:0]      spec_value;
    logic [15:0]      spec_rate;
    logic [31:0]      spec_fields;
    logic [PosW-1:0]  size;
    logic             first;
  } event_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  channel;
    logic [7:0]  sensor;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic [15:0] spec_size;
    logic [7:0]  pkt_total;
    logic [7:0]  pkt_index;
    logic [AsmW-1:0] assembled;
    logic        done;
    logic        device_first;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sdd_front.sv =====
// Front part: parses bytes and classifies each transaction into an event.
// Depends on sdd_pkg.
`default_nettype none
module sdd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            end_of_datagram_i,
  output sdd_pkg::event_t      event_o,
  output logic                 event_valid_o
);

  logic [sdd_pkg::PosW-1:0] pos_q, pos_d;
  logic [7:0]  type_q, type_d;
  logic        hdr_q, hdr_d, start_q, start_d, seen_q, seen_d;
  logic [sdd_pkg::RecW-1:0] rec_q, rec_d;
  logic [7:0]  ch_q, ch_d, sn_q, sn_d;
  logic [31:0] wa_q, wa_d, wb_q, wb_d, sf_q, sf_d;
  logic        take;
  logic [7:0]  pat;
  logic        rec_fire;
  sdd_pkg::event_t ev;

  always_comb begin
    case (pos_q)
      16'd0, 16'd1, 16'd2: pat = sdd_pkg::StartHigh;
      default:            pat = sdd_pkg::StartLow;
    endcase
  end

  always_comb begin
    pos_d = pos_q; type_d = type_q; hdr_d = hdr_q; start_d = start_q;
    rec_d = rec_q; ch_d = ch_q; sn_d = sn_q; wa_d = wa_q; wb_d = wb_q;
    sf_d = sf_q; seen_d = seen_q; rec_fire = 1'b0;
    take = valid_i && (32'(pos_q) < sdd_pkg::MaxDatagramBytes);
    if (take) begin
      if (pos_q < 16'd7 && data_byte_i != pat) start_d = 1'b0;
      if (pos_q < 16'd4 && data_byte_i != sdd_pkg::HeaderByte) hdr_d = 1'b0;
      if (pos_q == 16'd4) type_d = data_byte_i;
      if (pos_q >= 16'd5 && hdr_q && type_q == sdd_pkg::TypeRealtime) begin
        if (rec_q == 6'd0) ch_d = data_byte_i;
        else if (rec_q == 6'd1) sn_d = data_byte_i;
        else if (rec_q < 6'd6) wa_d = {wa_q[23:0], data_byte_i};
        else if (rec_q < 6'd10) wb_d = {wb_q[23:0], data_byte_i};
        if (32'(rec_q) + 32'd1 >= sdd_pkg::RecordBytes) begin
          rec_fire = 1'b1;
          rec_d = '0;
        end else begin
          rec_d = rec_q + 6'd1;
        end
      end
      if (pos_q >= 16'd5 && hdr_q && type_q == sdd_pkg::TypeSpectrum) begin
        if (pos_q == 16'd5) ch_d = data_byte_i;
        else if (pos_q == 16'd6) sn_d = data_byte_i;
        else if (pos_q < 16'd9) wb_d = {16'd0, wb_q[7:0], data_byte_i};
        else if (pos_q < 16'd13) sf_d = {sf_q[23:0], data_byte_i};
        else if (pos_q < 16'd17) wa_d = {wa_q[23:0], data_byte_i};
      end
      pos_d = pos_q + 16'd1;
    end

    ev = '0;
    ev.has_record = rec_fire;
    ev.rec_channel = ch_d; ev.rec_sensor = sn_d; ev.rec_a = wa_d; ev.rec_b = wb_d;
    ev.spec_channel = ch_d; ev.spec_sensor = sn_d; ev.spec_value = wa_d;
    ev.spec_rate = wb_d[15:0]; ev.spec_fields = sf_d; ev.size = pos_d;
    ev.first = !seen_q;
    ev.end_kind = sdd_pkg::KindUnknownType;
    if (valid_i && end_of_datagram_i) begin
      ev.has_end = 1'b1;
      if (start_d && pos_d == 16'd7) ev.end_kind = sdd_pkg::KindStart;
      else if (pos_d < 16'd4) ev.end_kind = sdd_pkg::KindShort;
      else if (!hdr_d) ev.end_kind = sdd_pkg::KindBadHeader;
      else if (pos_d < 16'd5) ev.end_kind = sdd_pkg::KindNoType;
      else if (type_d == sdd_pkg::TypeRealtime) ev.end_kind = sdd_pkg::KindRealtimeEnd;
      else if (type_d == sdd_pkg::TypeSpectrum) begin
        if (pos_d < sdd_pkg::SpecMin) ev.end_kind = sdd_pkg::KindSpectrumShort;
        else ev.end_kind = sdd_pkg::KindSpectrum;
      end
      seen_d = 1'b1;
      pos_d = '0; type_d = '0; hdr_d = 1'b1; start_d = 1'b1; rec_d = '0;
      ch_d = '0; sn_d = '0; wa_d = '0; wb_d = '0; sf_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; type_q <= '0; hdr_q <= 1'b1; start_q <= 1'b1; rec_q <= '0;
      ch_q <= '0; sn_q <= '0; wa_q <= '0; wb_q <= '0; sf_q <= '0; seen_q <= 1'b0;
    end else if (valid_i) begin
      pos_q <= pos_d; type_q <= type_d; hdr_q <= hdr_d; start_q <= start_d;
      rec_q <= rec_d; ch_q <= ch_d; sn_q <= sn_d; wa_q <= wa_d; wb_q <= wb_d;
      sf_q <= sf_d; seen_q <= seen_d;
    end
  end

  assign event_o = ev;
  assign event_valid_o = valid_i && (ev.has_record || ev.has_end);

endmodule
`default_nettype wire

// ===== hw/rtl/sdd_queue.sv =====
// Short event queue between the front and back parts.
// Depends on sdd_pkg.
`default_nettype none
module sdd_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_i,
  input  sdd_pkg::event_t      wr_data_i,
  output logic                 almost_full_o,
  input  wire logic            rd_i,
  output sdd_pkg::event_t      rd_data_o,
  output logic                 empty_o
);

  sdd_pkg::event_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 2'd1;
      if (rd_i) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(wr_i) - 3'(rd_i);
    end
  end

  assign rd_data_o = mem_q[rp_q];
  assign empty_o = (cnt_q == 3'd0);
  assign almost_full_o = (cnt_q >= 3'd3);

endmodule
`default_nettype wire

// ===== hw/rtl/sdd_back.sv =====
// Back part: expands events into results, keeps the reassembly length.
// Depends on sdd_pkg.
`default_nettype none
module sdd_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  sdd_pkg::event_t      ev_i,
  input  wire logic            ev_empty_i,
  output logic                 ev_pop_o,
  output sdd_pkg::result_t     res_o,
  output logic                 res_empty_o,
  input  wire logic            res_pop_i
);

  logic [sdd_pkg::AsmW-1:0] asm_q, asm_d;
  logic part_q;
  logic out_v_q;
  sdd_pkg::result_t out_q, r;
  logic step, second, finish;
  logic [7:0] tp, pn;
  logic [sdd_pkg::PosW-1:0] extra;
  logic [sdd_pkg::AsmW:0] sum;

  assign step = !ev_empty_i && (!out_v_q || res_pop_i);
  assign second = part_q || !ev_i.has_record;

  always_comb begin
    r = '0;
    asm_d = asm_q;
    tp = ev_i.spec_fields[15:8];
    pn = ev_i.spec_fields[7:0];
    extra = (ev_i.size > sdd_pkg::SpecValueEnd) ? ev_i.size - sdd_pkg::SpecValueEnd : '0;
    sum = '0;
    if (!second) begin
      r.kind = sdd_pkg::KindRecord;
      r.channel = ev_i.rec_channel; r.sensor = ev_i.rec_sensor;
      r.first_value = ev_i.rec_a; r.second_value = ev_i.rec_b;
      r.last = !ev_i.has_end;
    end else begin
      r.kind = ev_i.end_kind;
      r.device_first = ev_i.first;
      r.last = 1'b1;
      if (ev_i.end_kind == sdd_pkg::KindSpectrum) begin
        r.channel = ev_i.spec_channel; r.sensor = ev_i.spec_sensor;
        r.first_value = (ev_i.size >= sdd_pkg::SpecValueEnd) ? ev_i.spec_value : '0;
        r.second_value = {16'd0, ev_i.spec_rate};
        r.spec_size = ev_i.spec_fields[31:16];
        r.pkt_total = tp; r.pkt_index = pn;
        r.assembled = asm_q;
        if (tp > 8'd1) begin
          sum = (pn == 8'd1 ? '0 : {1'b0, asm_q}) + (sdd_pkg::AsmW+1)'(extra);
          r.assembled = sum[sdd_pkg::AsmW] ? sdd_pkg::AsmMax : sum[sdd_pkg::AsmW-1:0];
          asm_d = r.assembled;
          if (pn == tp) begin
            r.done = 1'b1;
            asm_d = '0;
          end
        end
      end
    end
  end

  assign finish = step && (second || !ev_i.has_end);
  assign ev_pop_o = finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asm_q <= '0; part_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      if (step) begin
        out_v_q <= 1'b1;
        part_q <= !finish;
        if (second) asm_q <= asm_d;
      end else if (res_pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_q <= r;
  end

  assign res_o = out_q;
  assign res_empty_o = !out_v_q;

endmodule
`default_nettype wire

// ===== hw/rtl/sensor_datagram_deframer.sv =====
// Top level of the sensor datagram deframer.
// Depends on sdd_pkg, sdd_front, sdd_queue and sdd_back.
//
// Channel  Direction  Handshake         Payload
// input    in         push_i / full_o   data_byte_i, end_of_datagram_i
// result   out        pop_i / empty_o   result_kind_o .. last_of_run_o
//
// One byte is taken per cycle while full_o is low; the front part decides everything per byte.
// A byte that causes a record and an end result gives two results, the record first.
// Each event passes through the four-entry queue and then the registered back-part output.
// full_o rises when three events wait; reset clears all framing state.
`default_nettype none
module sensor_datagram_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_datagram_i,
  input  wire logic        pop_i,
  output logic             empty_o,
  output logic [3:0]       result_kind_o,
  output logic [7:0]       channel_o,
  output logic [7:0]       sensor_o,
  output logic [31:0]      first_value_o,
  output logic [31:0]      second_value_o,
  output logic [15:0]      spec_size_o,
  output logic [7:0]       pkt_total_o,
  output logic [7:0]       pkt_index_o,
  output logic [23:0]      assembled_bytes_o,
  output logic             assembly_done_o,
  output logic             device_first_o,
  output logic             last_of_run_o
);

  sdd_pkg::event_t ev_w, ev_r;
  sdd_pkg::result_t res;
  logic ev_v, q_empty, q_pop, accept;

  assign accept = push_i && !full_o;

  sdd_front u_front (
    .clk_i, .rst_ni, .valid_i(accept), .data_byte_i, .end_of_datagram_i,
    .event_o(ev_w), .event_valid_o(ev_v)
  );

  sdd_queue u_queue (
    .clk_i, .rst_ni, .wr_i(ev_v), .wr_data_i(ev_w), .almost_full_o(full_o),
    .rd_i(q_pop), .rd_data_o(ev_r), .empty_o(q_empty)
  );

  sdd_back u_back (
    .clk_i, .rst_ni, .ev_i(ev_r), .ev_empty_i(q_empty), .ev_pop_o(q_pop),
    .res_o(res), .res_empty_o(empty_o), .res_pop_i(pop_i)
  );

  assign result_kind_o = res.kind;
  assign channel_o = res.channel;
  assign sensor_o = res.sensor;
  assign first_value_o = res.first_value;
  assign second_value_o = res.second_value;
  assign spec_size_o = res.spec_size;
  assign pkt_total_o = res.pkt_total;
  assign pkt_index_o = res.pkt_index;
  assign assembled_bytes_o = res.assembled;
  assign assembly_done_o = res.done;
  assign device_first_o = res.device_first;
  assign last_of_run_o = res.last;

endmodule
`default_nettype wire

// ===== dv/sensor_datagram_deframer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the sensor datagram deframer.
// Depends on sdd_pkg and sensor_datagram_deframer; results are checked against a local predictor.
module sensor_datagram_deframer_tb;

  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned BytesPerPhase = 185;

  typedef struct packed {
    logic [7:0]     data;
    logic           eod;
    logic           chk;
    sdd_pkg::kind_e kind;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push_i = 1'b0;
  logic        full_o;
  logic [7:0]  data_byte_i = '0;
  logic        end_of_datagram_i = 1'b0;
  logic        pop_i = 1'b0;
  logic        empty_o;
  logic [3:0]  result_kind_o;
  logic [7:0]  channel_o;
  logic [7:0]  sensor_o;
  logic [31:0] first_value_o;
  logic [31:0] second_value_o;
  logic [15:0] spec_size_o;
  logic [7:0]  pkt_total_o;
  logic [7:0]  pkt_index_o;
  logic [23:0] assembled_bytes_o;
  logic        assembly_done_o;
  logic        device_first_o;
  logic        last_of_run_o;

  sensor_datagram_deframer dut (.*);

  always #5 clk_i = ~clk_i;

  sdd_pkg::result_t pending_q[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned bytes_sent = 0;

  // Predictor state.
  int unsigned pos;
  logic [7:0]  frame_kind;
  logic        hdr_ok;
  logic        start_ok;
  int unsigned rec_cnt;
  logic [7:0]  chan;
  logic [7:0]  sens;
  logic [31:0] word_a;
  logic [31:0] word_b;
  logic [31:0] spec_fields;
  logic        seen_device;
  int unsigned asm_len;
  int unsigned new_results;
  sdd_pkg::kind_e newest_kind;

  // Reassembly sequence state for the stimulus.
  int unsigned seq_total = 0;
  int unsigned seq_next = 0;

  function automatic void clear_frame();
    pos = 0;
    frame_kind = '0;
    hdr_ok = 1'b1;
    start_ok = 1'b1;
    rec_cnt = 0;
    chan = '0;
    sens = '0;
    word_a = '0;
    word_b = '0;
    spec_fields = '0;
  endfunction

  function automatic void add_result(sdd_pkg::result_t r);
    pending_q.push_back(r);
    new_results++;
    newest_kind = r.kind;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic eod);
    sdd_pkg::result_t r;
    int unsigned size;
    int unsigned extra;
    logic [7:0]  pat;
    new_results = 0;
    if (pos < sdd_pkg::MaxDatagramBytes) begin
      pat = (pos < 3) ? sdd_pkg::StartHigh : sdd_pkg::StartLow;
      if (pos < 7 && b != pat) start_ok = 1'b0;
      if (pos < 4 && b != sdd_pkg::HeaderByte) hdr_ok = 1'b0;
      if (pos == 4) frame_kind = b;
      if (pos >= 5 && hdr_ok && frame_kind == sdd_pkg::TypeRealtime) begin
        if (rec_cnt == 0) chan = b;
        else if (rec_cnt == 1) sens = b;
        else if (rec_cnt < 6) word_a = {word_a[23:0], b};
        else if (rec_cnt < 10) word_b = {word_b[23:0], b};
        rec_cnt++;
        if (rec_cnt >= sdd_pkg::RecordBytes) begin
          r = '0;
          r.kind = sdd_pkg::KindRecord;
          r.channel = chan;
          r.sensor = sens;
          r.first_value = word_a;
          r.second_value = word_b;
          add_result(r);
          rec_cnt = 0;
        end
      end
      if (pos >= 5 && hdr_ok && frame_kind == sdd_pkg::TypeSpectrum) begin
        if (pos == 5) chan = b;
        else if (pos == 6) sens = b;
        else if (pos < 9) word_b = {16'h0, word_b[7:0], b};
        else if (pos < 13) spec_fields = {spec_fields[23:0], b};
        else if (pos < 17) word_a = {word_a[23:0], b};
      end
      pos++;
    end
    if (eod) begin
      size = pos;
      r = '0;
      r.device_first = !seen_device;
      if (start_ok && size == 7) r.kind = sdd_pkg::KindStart;
      else if (size < 4) r.kind = sdd_pkg::KindShort;
      else if (!hdr_ok) r.kind = sdd_pkg::KindBadHeader;
      else if (size < 5) r.kind = sdd_pkg::KindNoType;
      else if (frame_kind == sdd_pkg::TypeRealtime) r.kind = sdd_pkg::KindRealtimeEnd;
      else if (frame_kind == sdd_pkg::TypeSpectrum) begin
        if (size < sdd_pkg::SpecMin) r.kind = sdd_pkg::KindSpectrumShort;
        else begin
          r.kind = sdd_pkg::KindSpectrum;
          r.channel = chan;
          r.sensor = sens;
          r.first_value = (size >= sdd_pkg::SpecValueEnd) ? word_a : '0;
          r.second_value = word_b;
          r.spec_size = spec_fields[31:16];
          r.pkt_total = spec_fields[15:8];
          r.pkt_index = spec_fields[7:0];
          extra = (size > sdd_pkg::SpecValueEnd) ? size - sdd_pkg::SpecValueEnd : 0;
          if (r.pkt_total > 1) begin
            if (r.pkt_index == 1) asm_len = 0;
            asm_len += extra;
            if (asm_len > sdd_pkg::AsmMax) asm_len = sdd_pkg::AsmMax;
            if (r.pkt_index == r.pkt_total) begin
              r.done = 1'b1;
              r.assembled = asm_len;
              asm_len = 0;
            end else begin
              r.assembled = asm_len;
            end
          end else begin
            r.assembled = asm_len;
          end
        end
      end else r.kind = sdd_pkg::KindUnknownType;
      add_result(r);
      seen_device = 1'b1;
      clear_frame();
    end
    if (new_results > 0) pending_q[pending_q.size()-1].last = 1'b1;
  endfunction

  task automatic send_byte(logic [7:0] b, logic eod);
    while ($urandom_range(99) < send_idle) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i <= 1'b1;
    data_byte_i <= b;
    end_of_datagram_i <= eod;
    do @(posedge clk_i); while (full_o);
    bytes_sent++;
    predict_byte(b, eod);
  endtask

  task automatic send_frame(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  function automatic void add_random(ref logic [7:0] bytes[$], input int unsigned n);
    repeat (n) bytes.push_back($urandom_range(255));
  endfunction

  task automatic send_random_frame();
    logic [7:0]  bytes[$];
    int unsigned sel;
    int unsigned len;
    int unsigned tp;
    int unsigned pn;
    sel = $urandom_range(99);
    if (sel < 58) begin
      bytes = '{sdd_pkg::HeaderByte, sdd_pkg::HeaderByte, sdd_pkg::HeaderByte,
                sdd_pkg::HeaderByte};
    end
    if (sel < 28) begin
      bytes.push_back(sdd_pkg::TypeRealtime);
      add_random(bytes, sdd_pkg::RecordBytes * $urandom_range(0, 2) + $urandom_range(0, 39));
    end else if (sel < 58) begin
      if (seq_next == 0 || seq_next > seq_total) begin
        seq_total = $urandom_range(0, 4);
        seq_next = 1;
      end
      tp = seq_total;
      pn = ($urandom_range(9) == 0) ? $urandom_range(255) : seq_next;
      seq_next++;
      bytes.push_back(sdd_pkg::TypeSpectrum);
      add_random(bytes, 4);
      bytes.push_back($urandom_range(255));
      bytes.push_back($urandom_range(255));
      bytes.push_back(tp);
      bytes.push_back(pn);
      add_random(bytes, 4 + $urandom_range(0, 20));
      len = ($urandom_range(4) == 0) ? $urandom_range(5, 17) : bytes.size();
      while (bytes.size() > len) void'(bytes.pop_back());
    end else if (sel < 68) begin
      bytes = '{sdd_pkg::StartHigh, sdd_pkg::StartHigh, sdd_pkg::StartHigh,
                sdd_pkg::StartLow, sdd_pkg::StartLow, sdd_pkg::StartLow,
                sdd_pkg::StartLow};
      if ($urandom_range(2) == 0) bytes[$urandom_range(6)] = $urandom_range(255);
      else if ($urandom_range(1) == 0) bytes.push_back($urandom_range(255));
    end else if (sel < 76) begin
      add_random(bytes, $urandom_range(1, 3));
    end else if (sel < 84) begin
      bytes = '{sdd_pkg::HeaderByte, sdd_pkg::HeaderByte, sdd_pkg::HeaderByte,
                sdd_pkg::HeaderByte};
      add_random(bytes, $urandom_range(1, 10));
      bytes[$urandom_range(3)] = $urandom_range(254);
    end else if (sel < 90) begin
      bytes = '{sdd_pkg::HeaderByte, sdd_pkg::HeaderByte, sdd_pkg::HeaderByte,
                sdd_pkg::HeaderByte};
    end else begin
      add_random(bytes, $urandom_range(1, 20));
    end
    send_frame(bytes);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    sdd_pkg::result_t e;
    if (rst_ni) begin
      if (pop_i && !empty_o) begin
        if (pending_q.size() == 0) begin
          $error("unexpected result, kind %0d", result_kind_o);
          fail_count++;
        end else begin
          e = pending_q.pop_front();
          if (result_kind_o != e.kind) begin
            $error("result_kind: expected %0d, got %0d", e.kind, result_kind_o);
            fail_count++;
          end
          if (channel_o != e.channel) begin
            $error("channel: expected %0h, got %0h", e.channel, channel_o);
            fail_count++;
          end
          if (sensor_o != e.sensor) begin
            $error("sensor: expected %0h, got %0h", e.sensor, sensor_o);
            fail_count++;
          end
          if (first_value_o != e.first_value) begin
            $error("first_value: expected %0h, got %0h", e.first_value, first_value_o);
            fail_count++;
          end
          if (second_value_o != e.second_value) begin
            $error("second_value: expected %0h, got %0h", e.second_value, second_value_o);
            fail_count++;
          end
          if (spec_size_o != e.spec_size) begin
            $error("spec_size: expected %0h, got %0h", e.spec_size, spec_size_o);
            fail_count++;
          end
          if (pkt_total_o != e.pkt_total) begin
            $error("pkt_total: expected %0d, got %0d", e.pkt_total, pkt_total_o);
            fail_count++;
          end
          if (pkt_index_o != e.pkt_index) begin
            $error("pkt_index: expected %0d, got %0d", e.pkt_index, pkt_index_o);
            fail_count++;
          end
          if (assembled_bytes_o != e.assembled) begin
            $error("assembled_bytes: expected %0d, got %0d", e.assembled, assembled_bytes_o);
            fail_count++;
          end
          if (assembly_done_o != e.done) begin
            $error("assembly_done: expected %0b, got %0b", e.done, assembly_done_o);
            fail_count++;
          end
          if (device_first_o != e.device_first) begin
            $error("device_first: expected %0b, got %0b", e.device_first, device_first_o);
            fail_count++;
          end
          if (last_of_run_o != e.last) begin
            $error("last_of_run: expected %0b, got %0b", e.last, last_of_run_o);
            fail_count++;
          end
        end
      end
      pop_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    dir_row_t    dir_tab[21];
    int unsigned phase;
    int unsigned target;
    dir_tab = '{
      '{sdd_pkg::StartHigh, 1'b0, 1'b0, sdd_pkg::KindRecord},
      '{sdd_pkg::StartHigh, 1'b0, 1'b0, sdd_pkg::KindRecord},
      '{sdd_pkg::StartHigh, 1'b0, 1'b0, sdd_pkg::KindRecord},
      '{sdd_pkg::StartLow, 1'b0, 1'b0, sdd_pkg::KindRecord},
      '{sdd_pkg::StartLow, 1'b0, 1'b0, sdd_pkg::KindRecord},
      '{sdd_pkg::StartLow, 1'b0, 1'b0, sdd_pkg::KindRecord},
      '{sdd_pkg::StartLow, 1'b1, 1'b1, sdd_pkg::KindStart},
      '{8'h00, 1'b1, 1'b1, sdd_pkg::KindShort},
      '{8'hFF, 1'b0, 1'b0, sdd_pkg::KindRecord}, '{8'hFF, 1'b0, 1'b0, sdd_pkg::KindRecord},
      '{8'hFF, 1'b0, 1'b0, sdd_pkg::KindRecord}, '{8'h00, 1'b1, 1'b1, sdd_pkg::KindBadHeader},
      '{8'hFF, 1'b0, 1'b0, sdd_pkg::KindRecord}, '{8'hFF, 1'b0, 1'b0, sdd_pkg::KindRecord},
      '{8'hFF, 1'b0, 1'b0, sdd_pkg::KindRecord}, '{8'hFF, 1'b1, 1'b1, sdd_pkg::KindNoType},
      '{8'hFF, 1'b0, 1'b0, sdd_pkg::KindRecord}, '{8'hFF, 1'b0, 1'b0, sdd_pkg::KindRecord},
      '{8'hFF, 1'b0, 1'b0, sdd_pkg::KindRecord}, '{8'hFF, 1'b0, 1'b0, sdd_pkg::KindRecord},
      '{8'hFE, 1'b1, 1'b1, sdd_pkg::KindUnknownType}
    };
    clear_frame();
    seen_device = 1'b0;
    asm_len = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 26 : (phase == 1) ? 83 : 0;
      recv_idle = (phase == 0) ? 83 : (phase == 1) ? 26 : 0;
      target = bytes_sent + BytesPerPhase;
      if (phase == 0) begin
        foreach (dir_tab[i]) begin
          send_byte(dir_tab[i].data, dir_tab[i].eod);
          if (dir_tab[i].chk && (new_results == 0 || newest_kind != dir_tab[i].kind)) begin
            $error("result_kind: expected %0d, got %0d", dir_tab[i].kind, newest_kind);
            fail_count++;
          end
        end
      end
      while (bytes_sent < target) send_random_frame();
    end
    push_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sensor_datagram_deframer.f =====
hw/rtl/sdd_pkg.sv
hw/rtl/sdd_front.sv
hw/rtl/sdd_queue.sv
hw/rtl/sdd_back.sv
hw/rtl/sensor_datagram_deframer.sv
dv/sensor_datagram_deframer_tb.sv
